@@ rtl/core/cps_pkg.sv @@
// Shared types, constants and helper functions for the cart-pole state-feedback controller.
package cps_pkg;

  localparam int CNT_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int GX_W    = 24;
  localparam int SCL_W   = 16;
  localparam int OFS_W   = 10;
  localparam int DUTY_W  = 10;
  localparam int EFF_W   = 11;
  localparam int POS_W   = 32;
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = GX_W + DIFF_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int FRAC_W  = 24;
  localparam int Q_W     = ACC_W - FRAC_W;
  localparam int CIDX_W  = 3;
  localparam int CDAT_W  = 16;
  localparam int CMD_W   = 2;
  localparam int EFF_MAX = 1023;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_K_POS   = 3'd0,
    REG_K_VEL   = 3'd1,
    REG_K_ANG   = 3'd2,
    REG_K_RATE  = 3'd3,
    REG_C_SCALE = 3'd4,
    REG_A_SCALE = 3'd5,
    REG_OFFSET  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] k_pos;
    logic signed [GX_W-1:0]   k_vel100;
    logic signed [GAIN_W-1:0] k_ang;
    logic signed [GX_W-1:0]   k_rate100;
    logic [SCL_W-1:0]         cart_scale;
    logic [SCL_W-1:0]         angle_scale;
    logic [OFS_W-1:0]         pwm_offset;
  } cfg_t;

  // gain * 100 as shift-add: 64 + 32 + 4
  function automatic logic signed [GX_W-1:0] times100(input logic signed [GAIN_W-1:0] g);
    logic signed [GX_W-1:0] ext;
    begin
      ext = {{(GX_W-GAIN_W){g[GAIN_W-1]}}, g};
      return (ext <<< 6) + (ext <<< 5) + (ext <<< 2);
    end
  endfunction

  // drop fraction bits toward zero, saturate to +-EFF_MAX
  function automatic logic signed [EFF_W-1:0] trunc_sat(input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0]   mag;
    logic [Q_W-1:0]     q;
    logic [EFF_W-2:0]   m;
    logic [EFF_W-1:0]   pos;
    begin
      mag = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
      q   = mag[ACC_W-1:FRAC_W];
      m   = (q > Q_W'(EFF_MAX)) ? (EFF_W-1)'(EFF_MAX) : q[EFF_W-2:0];
      pos = {1'b0, m};
      return acc[ACC_W-1] ? EFF_W'(-pos) : pos;
    end
  endfunction

endpackage

@@ rtl/core/cps_cfg.sv @@
// Configuration register file: gains, scale factors and PWM offset.
module cps_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cps_pkg::CIDX_W-1:0] cfg_index,
  input  logic [cps_pkg::CDAT_W-1:0] cfg_wdata,
  output cps_pkg::cfg_t             cfg
);
  import cps_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.k_pos       <= 16'sd8582;
      cfg_r.k_vel100    <= times100(16'sd4498);
      cfg_r.k_ang       <= 16'sd32416;
      cfg_r.k_rate100   <= times100(16'sd7917);
      cfg_r.cart_scale  <= 16'd314;
      cfg_r.angle_scale <= 16'd10289;
      cfg_r.pwm_offset  <= 10'd120;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_K_POS:   cfg_r.k_pos       <= cfg_wdata;
        REG_K_VEL:   cfg_r.k_vel100    <= times100(cfg_wdata);
        REG_K_ANG:   cfg_r.k_ang       <= cfg_wdata;
        REG_K_RATE:  cfg_r.k_rate100   <= times100(cfg_wdata);
        REG_C_SCALE: cfg_r.cart_scale  <= cfg_wdata;
        REG_A_SCALE: cfg_r.angle_scale <= cfg_wdata;
        REG_OFFSET:  cfg_r.pwm_offset  <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/cps_mul.sv @@
// Shared signed multiplier with registered product.
module cps_mul (
  input  logic                              clk,
  input  logic signed [cps_pkg::GX_W-1:0]   op_a,
  input  logic signed [cps_pkg::DIFF_W-1:0] op_b,
  output logic signed [cps_pkg::PROD_W-1:0] prod
);
  import cps_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a * op_b);
  end

  assign prod = prod_r;

endmodule

@@ rtl/core/cps_pwm.sv @@
// Effort to PWM duty and direction mapping with deadband offset.
module cps_pwm (
  input  logic signed [cps_pkg::EFF_W-1:0] effort,
  input  logic [cps_pkg::OFS_W-1:0]        pwm_offset,
  input  logic                             held_dir,
  output logic [cps_pkg::DUTY_W-1:0]       duty,
  output logic                             dir
);
  import cps_pkg::*;

  logic [EFF_W-1:0] mag;
  logic [EFF_W-1:0] sum;

  always_comb begin
    mag = effort[EFF_W-1] ? EFF_W'(-effort) : effort;
    sum = {1'b0, pwm_offset} + mag;
    if (effort[EFF_W-1] || effort > EFF_W'(1)) begin
      duty = (sum > EFF_W'(EFF_MAX)) ? DUTY_W'(EFF_MAX) : sum[DUTY_W-1:0];
      dir  = !effort[EFF_W-1];
    end else begin
      duty = '0;
      dir  = held_dir;
    end
  end

endmodule

@@ rtl/core/cart_pole_state_feedback.sv @@
// Cart-pole state-feedback controller top level: sequencer, accumulator and stream ports.
//
// One request is taken at a time. A control tick while running walks the sequencer through
// two scale multiplies and four gain multiplies on a single shared 24x33 multiplier, one
// step to fold the last product into the accumulator, one effort truncation step and one
// output step, which raises out_tvalid; no new request is taken until it is back in idle.
// Start, stop, unused commands and ticks while stopped go from idle straight to the output
// step. The result sits in an output register, so a new request is taken once the sequencer
// is back in idle even if the previous result has not been drained yet; a finished result
// waits in the output step for that register to free up, and waiting there delays the next
// request.
module cart_pole_state_feedback (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // cart_count[15:0], angle_count[31:16]
  input  logic [cps_pkg::CMD_W-1:0]   in_tuser,   // cmd[1:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // effort[10:0], pwm_duty[20:11],
                                                  // motor_direction[21], running[22]
  input  logic                        cfg_wr_en,
  input  logic [cps_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [cps_pkg::CDAT_W-1:0]  cfg_wdata
);
  import cps_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_SC   = 10'b00_0000_0010,
    S_SA   = 10'b00_0000_0100,
    S_M1   = 10'b00_0000_1000,
    S_M2   = 10'b00_0001_0000,
    S_M3   = 10'b00_0010_0000,
    S_M4   = 10'b00_0100_0000,
    S_ACC  = 10'b00_1000_0000,
    S_EFF  = 10'b01_0000_0000,
    S_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  cfg_t cfg;
  logic signed [GX_W-1:0]   op_a;
  logic signed [DIFF_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [CNT_W-1:0]  cc_r, ac_r;
  logic signed [POS_W-1:0]  s_r, th_r, prev_s_r, prev_a_r;
  logic signed [DIFF_W-1:0] ds_r, dth_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [EFF_W-1:0]  effort_r;
  logic                     run_r, held_dir_r;
  logic                     out_tvalid_r;
  logic [23:0]              out_tdata_r;
  logic [DUTY_W-1:0]        duty;
  logic                     dir;
  logic                     in_acc, out_load;
  cmd_t                     cmd;

  cps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cps_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  cps_pwm u_pwm (
    .effort     (effort_r),
    .pwm_offset (cfg.pwm_offset),
    .held_dir   (held_dir_r),
    .duty       (duty),
    .dir        (dir)
  );

  assign cmd       = cmd_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_SC: begin
        op_a = GX_W'(cc_r);
        op_b = signed'({{(DIFF_W-SCL_W){1'b0}}, cfg.cart_scale});
      end
      S_SA: begin
        op_a = GX_W'(ac_r);
        op_b = signed'({{(DIFF_W-SCL_W){1'b0}}, cfg.angle_scale});
      end
      S_M1: begin
        op_a = GX_W'(cfg.k_pos);
        op_b = DIFF_W'(s_r);
      end
      S_M2: begin
        op_a = cfg.k_vel100;
        op_b = ds_r;
      end
      S_M3: begin
        op_a = GX_W'(cfg.k_ang);
        op_b = DIFF_W'(th_r);
      end
      S_M4: begin
        op_a = cfg.k_rate100;
        op_b = dth_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = (cmd == CMD_TICK && run_r) ? S_SC : S_OUT;
      S_SC:   state_nxt = S_SA;
      S_SA:   state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_ACC;
      S_ACC:  state_nxt = S_EFF;
      S_EFF:  state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      run_r        <= 1'b0;
      held_dir_r   <= 1'b0;
      prev_s_r     <= '0;
      prev_a_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (cmd == CMD_START) run_r <= 1'b1;
        else if (cmd == CMD_STOP) run_r <= 1'b0;
      end
      if (state_r == S_EFF) begin
        prev_s_r <= s_r;
        prev_a_r <= th_r;
      end
      if (out_load) begin
        held_dir_r   <= dir;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cc_r     <= in_tdata[15:0];
      ac_r     <= in_tdata[31:16];
      effort_r <= '0;
    end
    unique case (state_r)
      S_SA:  s_r   <= prod[POS_W-1:0];
      S_M1: begin
        th_r <= prod[POS_W-1:0];
        ds_r <= DIFF_W'(s_r) - DIFF_W'(prev_s_r);
      end
      S_M2: begin
        acc_r <= ACC_W'(prod);
        dth_r <= DIFF_W'(th_r) - DIFF_W'(prev_a_r);
      end
      S_M3:  acc_r <= acc_r + ACC_W'(prod);
      S_M4:  acc_r <= acc_r - ACC_W'(prod);
      S_ACC: acc_r <= acc_r - ACC_W'(prod);
      S_EFF: effort_r <= trunc_sat(acc_r);
      default: ;
    endcase
    if (out_load) out_tdata_r <= {1'b0, run_r, dir, duty, effort_r};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_effort_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:0] != 11'h400)
    else $error("effort outside saturation range");

  a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20:11] == '0 |-> out_tdata[10:0] == 11'd0 ||
                                              out_tdata[10:0] == 11'd1)
    else $error("zero duty with nonzero drive effort");

  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[22] |-> out_tdata[20:0] == '0 || out_tdata[20:11] == '0)
    else $error("output driven while stopped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

endmodule

@@ bench/cart_pole_state_feedback_tb.sv @@
// Self-checking bench for the cart-pole state-feedback controller: stream requests, tracked PWM results.
module cart_pole_state_feedback_tb;
  import cps_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DUTY_CAP    = (1 << DUTY_W) - 1;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 175;

  typedef struct {
    bit signed [EFF_W-1:0] effort;
    bit [DUTY_W-1:0]       duty;
    bit                    dir;
    bit                    run;
  } pwm_result_t;

  class controller_mirror;
    bit signed [GAIN_W-1:0] k_pos, k_vel, k_ang, k_rate;
    bit [SCL_W-1:0]         c_scale, a_scale;
    bit [OFS_W-1:0]         offset;
    longint                 prev_pos, prev_ang;
    bit                     run, dir;
    pwm_result_t            awaited_pwm[$];
    int                     fails;

    function new();
      k_pos = 16'sd8582;
      k_vel = 16'sd4498;
      k_ang = 16'sd32416;
      k_rate = 16'sd7917;
      c_scale = 16'd314;
      a_scale = 16'd10289;
      offset = 10'd120;
      prev_pos = 0;
      prev_ang = 0;
      run = 1'b0;
      dir = 1'b0;
      fails = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [CDAT_W-1:0] v);
      case (idx)
        REG_K_POS:   k_pos = v;
        REG_K_VEL:   k_vel = v;
        REG_K_ANG:   k_ang = v;
        REG_K_RATE:  k_rate = v;
        REG_C_SCALE: c_scale = v;
        REG_A_SCALE: a_scale = v;
        REG_OFFSET:  offset = v[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(cmd_t cmd, bit signed [CNT_W-1:0] cart,
                               bit signed [CNT_W-1:0] angle);
      longint s, th, a, b, sum, q;
      int e, du;
      pwm_result_t r;
      e = 0;
      du = 0;
      if (cmd == CMD_START) begin
        run = 1'b1;
      end else if (cmd == CMD_STOP) begin
        run = 1'b0;
      end else if (cmd == CMD_TICK && run) begin
        s  = longint'(cart) * longint'(c_scale);
        th = longint'(angle) * longint'(a_scale);
        a  = longint'(k_pos) * s + longint'(k_vel) * (100 * (s - prev_pos));
        b  = longint'(k_ang) * th + longint'(k_rate) * (100 * (th - prev_ang));
        sum = a - b;
        // truncate toward zero
        if (sum < 0) q = -((-sum) >>> FRAC_W);
        else q = sum >>> FRAC_W;
        if (q > EFF_MAX) q = EFF_MAX;
        if (q < -EFF_MAX) q = -EFF_MAX;
        e = int'(q);
        if (e < 0) begin
          du = int'(offset) - e;
          dir = 1'b0;
        end else if (e > 1) begin
          du = int'(offset) + e;
          dir = 1'b1;
        end
        if (du > DUTY_CAP) du = DUTY_CAP;
        prev_pos = s;
        prev_ang = th;
      end
      r.effort = e[EFF_W-1:0];
      r.duty = du[DUTY_W-1:0];
      r.dir = dir;
      r.run = run;
      awaited_pwm.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_response(logic [23:0] d);
      pwm_result_t x;
      if (awaited_pwm.size() == 0) begin
        report($sformatf("result %h with no request pending", d));
      end else begin
        x = awaited_pwm.pop_front();
        if (d[10:0] !== x.effort)
          report($sformatf("effort %h, want %h", d[10:0], x.effort));
        if (d[20:11] !== x.duty)
          report($sformatf("pwm_duty %0d, want %0d", d[20:11], x.duty));
        if (d[21] !== x.dir)
          report($sformatf("motor_direction %b, want %b", d[21], x.dir));
        if (d[22] !== x.run)
          report($sformatf("running %b, want %b", d[22], x.run));
        if (d[23] !== 1'b0)
          report($sformatf("pad bit %b, want 0", d[23]));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;
  logic [CMD_W-1:0]   in_tuser = CMD_TICK;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [23:0]        out_tdata;
  logic               cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = REG_K_POS;
  logic [CDAT_W-1:0]  cfg_wdata = '0;

  controller_mirror   mirror;
  bit                 steady;
  logic [CDAT_W-1:0]  next_cfg[7];
  logic [CNT_W-1:0]   last_cart, last_angle;
  int                 quiet_cycles = 0;

  cart_pole_state_feedback dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mirror.check_response(out_tdata);
    out_tready <= steady || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("cart_pole_state_feedback test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_request(cmd_t cmd, logic [CNT_W-1:0] cart, logic [CNT_W-1:0] angle);
    while (!steady && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {angle, cart};
    do @(posedge clk); while (!in_tready);
    mirror.note_request(cmd, cart, angle);
    last_cart = cart;
    last_angle = angle;
  endtask

  function automatic logic [CNT_W-1:0] next_count(logic [CNT_W-1:0] last);
    int r;
    r = $urandom_range(99);
    if (r < 70) return last + CNT_W'($urandom_range(40)) - CNT_W'(20);
    if (r < 90) return CNT_W'($urandom);
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  task automatic random_item();
    int r;
    cmd_t c;
    r = $urandom_range(99);
    c = (r < 88) ? CMD_TICK : (r < 94) ? CMD_START : (r < 97) ? CMD_STOP : CMD_NOP;
    push_request(c, next_count(last_cart), next_count(last_angle));
  endtask

  // let every pending result come back before touching the registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.awaited_pwm.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings();
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= next_cfg[i];
      @(posedge clk);
      mirror.write_reg(reg_idx_t'(i), next_cfg[i]);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [CDAT_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return CDAT_W'($urandom);
      1: return CDAT_W'($urandom_range(1024)) - CDAT_W'(512);
      2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return CDAT_W'($urandom_range(64)) - CDAT_W'(32);
    endcase
  endfunction

  function automatic logic [CDAT_W-1:0] pick_scale();
    case ($urandom_range(2))
      0: return CDAT_W'($urandom);
      1: return CDAT_W'($urandom_range(2000));
      default: return $urandom_range(1) ? 16'hffff : 16'h0000;
    endcase
  endfunction

  initial begin
    mirror = new();
    steady = 1'b0;
    last_cart = '0;
    last_angle = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stopped tick, unused command, run/stop with stale history
    push_request(CMD_TICK, 16'd100, -16'sd50);
    push_request(CMD_NOP, 16'h7fff, 16'h8000);
    push_request(CMD_START, 16'h0000, 16'h0000);
    push_request(CMD_TICK, 16'h0000, 16'h0000);
    push_request(CMD_TICK, 16'h7fff, 16'h0000);
    push_request(CMD_TICK, 16'h8000, 16'h0000);
    push_request(CMD_TICK, 16'h0000, 16'h7fff);
    push_request(CMD_TICK, 16'h0000, 16'h8000);
    push_request(CMD_TICK, 16'd10, 16'd3);
    push_request(CMD_TICK, 16'd10, 16'd3);
    push_request(CMD_NOP, 16'd10, 16'd3);
    push_request(CMD_STOP, 16'd0, 16'd0);
    push_request(CMD_TICK, 16'd500, -16'sd500);
    push_request(CMD_START, 16'd0, 16'd0);
    push_request(CMD_TICK, 16'd12, 16'd4);
    drain();

    // unit gain on position: efforts of exactly 1, -1, 2 and small negative sums
    next_cfg[REG_K_POS] = 16'd1;
    next_cfg[REG_K_VEL] = 16'd0;
    next_cfg[REG_K_ANG] = 16'd0;
    next_cfg[REG_K_RATE] = 16'd0;
    next_cfg[REG_C_SCALE] = 16'd32768;
    next_cfg[REG_A_SCALE] = 16'd0;
    next_cfg[REG_OFFSET] = 16'd1023;
    load_settings();
    push_request(CMD_TICK, 16'd1024, 16'd0);
    push_request(CMD_TICK, 16'd512, 16'h7fff);
    push_request(CMD_TICK, 16'd511, 16'd0);
    push_request(CMD_TICK, -16'sd512, 16'd0);
    push_request(CMD_TICK, -16'sd511, 16'd0);
    push_request(CMD_TICK, -16'sd513, 16'd0);
    push_request(CMD_TICK, 16'd512, 16'd0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          for (int i = 0; i < 4; i++) next_cfg[i] = 16'h7fff;
          next_cfg[REG_C_SCALE] = 16'hffff;
          next_cfg[REG_A_SCALE] = 16'hffff;
          next_cfg[REG_OFFSET] = 16'd0;
        end
        1: begin
          for (int i = 0; i < 4; i++) next_cfg[i] = 16'h8000;
          next_cfg[REG_C_SCALE] = 16'hffff;
          next_cfg[REG_A_SCALE] = 16'hffff;
          next_cfg[REG_OFFSET] = 16'd1023;
        end
        2: begin
          for (int i = 0; i < 7; i++) next_cfg[i] = 16'd0;
        end
        default: begin
          for (int i = 0; i < 4; i++) next_cfg[i] = pick_gain();
          next_cfg[REG_C_SCALE] = pick_scale();
          next_cfg[REG_A_SCALE] = pick_scale();
          next_cfg[REG_OFFSET] = CDAT_W'($urandom_range(DUTY_CAP));
        end
      endcase
      load_settings();
      steady = (p == 6);
      push_request(CMD_START, last_cart, last_angle);
      for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      drain();
    end
    steady = 1'b0;

    repeat (20) @(posedge clk);
    if (mirror.fails == 0) begin
      $display("cart_pole_state_feedback test passed");
    end else begin
      $display("cart_pole_state_feedback test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/cps_pkg.sv
rtl/core/cps_cfg.sv
rtl/core/cps_mul.sv
rtl/core/cps_pwm.sv
rtl/core/cart_pole_state_feedback.sv
bench/cart_pole_state_feedback_tb.sv
